FILE: hw/rtl/vq_nearest_codeword_encoder_top_assert.svh
// assertion macros used by the encoder top
`ifndef VQ_NEAREST_CODEWORD_ENCODER_TOP_ASSERT_SVH
`define VQ_NEAREST_CODEWORD_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTH
`define VQE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vqe assertion failed");
`define VQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vqe assertion failed");
`else
`define VQE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VQE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/vqe_pkg.sv
package vqe_pkg;

    localparam int MAX_CENTROIDS = 32;
    localparam int VECTOR_LEN    = 25;

    localparam int DATA_W  = 16;
    localparam int PIX_W   = 8;
    localparam int FRAC_W  = 8;
    localparam int CIDX_W  = 5;
    localparam int KIDX_W  = 5;
    localparam int CFG_W   = 6;
    localparam int SUM_W   = 40;
    localparam int SQ_W    = 32;

    localparam int IDX_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int CNT_W  = $clog2(MAX_CENTROIDS + 1);
    localparam int ADDR_W = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int POS_W  = $clog2(VECTOR_LEN + 1);

    localparam int ACTIVE_RESET = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // one item travelling down the cell row
    typedef struct packed {
        logic              vld;
        logic              load;
        logic              wr;
        logic [CIDX_W-1:0] cidx;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              acc;
        logic              last;
        logic              best_vld;
        logic [SUM_W-1:0]  best_sum;
        logic [IDX_W-1:0]  best_idx;
    } t_tok;

    // codeword readout request, same to every cell
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_READ,
        S_SHOW
    } t_state;

endpackage

FILE: hw/rtl/vqe_in_if.sv
interface vqe_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [vqe_pkg::CIDX_W-1:0]  centroid_index;
    logic [vqe_pkg::KIDX_W-1:0]  component_index;
    logic [vqe_pkg::DATA_W-1:0]  codeword_value;
    logic [vqe_pkg::PIX_W-1:0]   pixel;
    logic                        last_pixel;

    modport source (
        output valid, func, centroid_index, component_index, codeword_value, pixel,
               last_pixel,
        input  ready
    );
    modport sink (
        input  valid, func, centroid_index, component_index, codeword_value, pixel,
               last_pixel,
        output ready
    );
endinterface

FILE: hw/rtl/vqe_out_if.sv
interface vqe_out_if;
    logic                        valid;
    logic                        ready;
    logic [vqe_pkg::CIDX_W-1:0]  chosen_centroid;
    logic [vqe_pkg::DATA_W-1:0]  replaced_value;
    logic                        last_of_run;

    modport source (
        output valid, chosen_centroid, replaced_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, chosen_centroid, replaced_value, last_of_run,
        output ready
    );
endinterface

FILE: hw/rtl/vq_nearest_codeword_encoder_top.sv
// throughput: loads and pixels one item per cycle; after a last pixel the input
//   stalls until the final result of the run sits in the output register
// a run of VECTOR_LEN results comes out one result at a time, each through the READ
//   and SHOW states, which wait on the registered codeword read of the chosen cell
// reset (i_rst_n low, synchronous) clears sums, position, flow state and sets
//   active_centroids to 32; the codebook keeps its contents and must be loaded
`include "vq_nearest_codeword_encoder_top_assert.svh"

module vq_nearest_codeword_encoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vqe_pkg::CFG_W-1:0]   i_cfg_wdata,
    vqe_in_if.sink                      i_item,
    vqe_out_if.source                   o_item
);

    localparam logic [vqe_pkg::ADDR_W-1:0] LAST_K = vqe_pkg::ADDR_W'(vqe_pkg::VECTOR_LEN - 1);

    // configuration
    logic [vqe_pkg::CFG_W-1:0]  r_active;
    logic [vqe_pkg::CNT_W-1:0]  active_eff;

    // flow control
    vqe_pkg::t_state            r_state;
    vqe_pkg::t_state            n_state;
    logic                       in_ready;
    logic                       in_acc;
    logic                       in_pix;
    logic                       out_free;
    logic                       out_load;
    vqe_pkg::t_rd               rd;

    // position within the vector being encoded
    logic [vqe_pkg::POS_W-1:0]  r_pos;
    logic [vqe_pkg::POS_W-1:0]  n_pos;
    logic                       pos_acc;

    // cell row
    vqe_pkg::t_tok              r_tok0;
    vqe_pkg::t_tok              n_tok0;
    vqe_pkg::t_tok              chain [vqe_pkg::MAX_CENTROIDS + 1];
    logic [vqe_pkg::DATA_W-1:0] cell_rdata [vqe_pkg::MAX_CENTROIDS];
    logic                       chain_done;

    // run emission
    logic [vqe_pkg::IDX_W-1:0]  r_best;
    logic [vqe_pkg::ADDR_W-1:0] r_k;
    logic                       r_out_vld;
    logic [vqe_pkg::CIDX_W-1:0] r_out_idx;
    logic [vqe_pkg::DATA_W-1:0] r_out_val;
    logic                       r_out_last;

    // zero counts as one, anything past the row counts as the full row
    always_comb begin
        if (r_active == '0) begin
            active_eff = vqe_pkg::CNT_W'(1);
        end else if (int'(r_active) > vqe_pkg::MAX_CENTROIDS) begin
            active_eff = vqe_pkg::CNT_W'(vqe_pkg::MAX_CENTROIDS);
        end else begin
            active_eff = vqe_pkg::CNT_W'(r_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= vqe_pkg::CFG_W'(vqe_pkg::ACTIVE_RESET);
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // handshake and item decode
    assign i_item.ready = in_ready;
    assign in_acc  = i_item.valid && in_ready;
    assign in_pix  = in_acc && (i_item.func == vqe_pkg::FUNC_PIXEL);
    assign pos_acc = int'(r_pos) < vqe_pkg::VECTOR_LEN;

    // build the item that enters cell 0; loads ride the row too so that
    // codeword writes stay in order with the pixels ahead of them
    always_comb begin
        n_tok0 = '0;
        if (in_acc) begin
            n_tok0.vld  = 1'b1;
            n_tok0.load = (i_item.func == vqe_pkg::FUNC_LOAD);
            n_tok0.cidx = i_item.centroid_index;
            n_tok0.wr   = (int'(i_item.component_index) < vqe_pkg::VECTOR_LEN)
                          && (int'(i_item.centroid_index) < vqe_pkg::MAX_CENTROIDS);
            if (i_item.func == vqe_pkg::FUNC_LOAD) begin
                n_tok0.addr = vqe_pkg::ADDR_W'(i_item.component_index);
                n_tok0.data = i_item.codeword_value;
            end else begin
                n_tok0.addr = r_pos[vqe_pkg::ADDR_W-1:0];
                n_tok0.data = {i_item.pixel, {vqe_pkg::FRAC_W{1'b0}}};
                n_tok0.acc  = pos_acc;
                n_tok0.last = i_item.last_pixel;
            end
        end
    end

    // excess pixels leave the position parked at the vector length
    always_comb begin
        n_pos = r_pos;
        if (in_pix) begin
            if (i_item.last_pixel) begin
                n_pos = '0;
            end else if (pos_acc) begin
                n_pos = r_pos + vqe_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0 <= '0;
            r_pos  <= '0;
        end else begin
            r_tok0 <= n_tok0;
            r_pos  <= n_pos;
        end
    end

    // row of distance cells; the running best index travels with the last pixel
    assign chain[0] = r_tok0;

    for (genvar g = 0; g < vqe_pkg::MAX_CENTROIDS; g++) begin : g_cell
        vqe_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (vqe_pkg::IDX_W'(g)),
            .i_active   (active_eff),
            .i_rd       (rd),
            .i_tok      (chain[g]),
            .o_tok      (chain[g+1]),
            .o_rdata    (cell_rdata[g])
        );
    end

    assign chain_done = chain[vqe_pkg::MAX_CENTROIDS].vld
                        && !chain[vqe_pkg::MAX_CENTROIDS].load
                        && chain[vqe_pkg::MAX_CENTROIDS].last;

    // output register frees when empty or taken this cycle
    assign out_free = !r_out_vld || o_item.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vqe_pkg::S_IDLE: begin
                if (in_pix && i_item.last_pixel) begin
                    n_state = vqe_pkg::S_DRAIN;
                end
            end
            vqe_pkg::S_DRAIN: begin
                if (chain_done) begin
                    n_state = vqe_pkg::S_READ;
                end
            end
            vqe_pkg::S_READ: begin
                n_state = vqe_pkg::S_SHOW;
            end
            vqe_pkg::S_SHOW: begin
                if (out_free) begin
                    n_state = (r_k == LAST_K) ? vqe_pkg::S_IDLE : vqe_pkg::S_READ;
                end
            end
            default: begin
                n_state = vqe_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        rd.en    = 1'b0;
        rd.addr  = r_k;
        case (r_state)
            vqe_pkg::S_IDLE: begin
                in_ready = 1'b1;
            end
            vqe_pkg::S_DRAIN: begin
                in_ready = 1'b0;
            end
            vqe_pkg::S_READ: begin
                rd.en = 1'b1;
            end
            vqe_pkg::S_SHOW: begin
                rd.en    = 1'b1;
                out_load = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vqe_pkg::S_IDLE;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_k <= (r_k == LAST_K) ? '0 : r_k + vqe_pkg::ADDR_W'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_item.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (chain_done && (r_state == vqe_pkg::S_DRAIN)) begin
            r_best <= chain[vqe_pkg::MAX_CENTROIDS].best_idx;
        end
        if (out_load) begin
            r_out_idx  <= vqe_pkg::CIDX_W'(r_best);
            r_out_val  <= cell_rdata[r_best];
            r_out_last <= (r_k == LAST_K);
        end
    end

    assign o_item.valid           = r_out_vld;
    assign o_item.chosen_centroid = r_out_idx;
    assign o_item.replaced_value  = r_out_val;
    assign o_item.last_of_run     = r_out_last;

    // a finished vector leaves the row only while the encoder waits for it
    `VQE_ASSERT_SAME(a_done_in_drain, i_clk, i_rst_n, chain_done, r_state == vqe_pkg::S_DRAIN)
    // run counter stays at zero outside the readout
    `VQE_ASSERT_SAME(a_k_idle, i_clk, i_rst_n, (r_state == vqe_pkg::S_IDLE) || (r_state == vqe_pkg::S_DRAIN), r_k == '0)
    // position restarts once a vector has ended
    `VQE_ASSERT_NEXT(a_pos_clear, i_clk, i_rst_n, in_pix && i_item.last_pixel, r_pos == '0)

endmodule

FILE: hw/rtl/vqe_ram.sv
module vqe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 25
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/vqe_cell.sv
module vqe_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [vqe_pkg::IDX_W-1:0]    i_cell_idx,
    input  logic [vqe_pkg::CNT_W-1:0]    i_active,
    input  vqe_pkg::t_rd                 i_rd,
    input  vqe_pkg::t_tok                i_tok,
    output vqe_pkg::t_tok                o_tok,
    output logic [vqe_pkg::DATA_W-1:0]   o_rdata
);

    logic                              ram_we;
    logic [vqe_pkg::ADDR_W-1:0]        ram_addr;
    logic [vqe_pkg::DATA_W-1:0]        ram_rdata;

    vqe_pkg::t_tok                     r_tok_b;
    vqe_pkg::t_tok                     r_tok_c;
    vqe_pkg::t_tok                     r_tok_o;
    vqe_pkg::t_tok                     n_tok_o;

    logic signed [vqe_pkg::DATA_W:0]     diff;
    logic signed [2*vqe_pkg::DATA_W+1:0] prod;
    logic [vqe_pkg::SQ_W-1:0]            r_sq;

    logic [vqe_pkg::SUM_W-1:0]         r_sum;
    logic [vqe_pkg::SUM_W-1:0]         n_sum;
    logic [vqe_pkg::SUM_W:0]           sum_add;
    logic [vqe_pkg::SUM_W-1:0]         sum_acc;
    logic [vqe_pkg::SUM_W-1:0]         sum_fin;
    logic                              is_pix;
    logic                              in_search;

    // stage a: codeword write or read for the item at this cell
    assign ram_we = i_tok.vld && i_tok.load && i_tok.wr && !i_rd.en
                    && (int'(i_tok.cidx) == int'(i_cell_idx));
    assign ram_addr = i_rd.en ? i_rd.addr : i_tok.addr;

    vqe_ram #(
        .WIDTH (vqe_pkg::DATA_W),
        .DEPTH (vqe_pkg::VECTOR_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_tok.data),
        .o_rdata (ram_rdata)
    );

    // stage b: squared difference
    assign diff = $signed({1'b0, r_tok_b.data}) - $signed({1'b0, ram_rdata});
    assign prod = diff * diff;

    // stage c: saturating accumulate, compare on the last pixel
    always_comb begin
        sum_add   = {1'b0, r_sum} + (vqe_pkg::SUM_W + 1)'(r_sq);
        sum_acc   = sum_add[vqe_pkg::SUM_W] ? vqe_pkg::SUM_MAX
                                            : sum_add[vqe_pkg::SUM_W-1:0];
        is_pix    = r_tok_c.vld && !r_tok_c.load;
        sum_fin   = (is_pix && r_tok_c.acc) ? sum_acc : r_sum;
        n_sum     = (is_pix && r_tok_c.last) ? '0 : sum_fin;
        in_search = vqe_pkg::CNT_W'(i_cell_idx) < i_active;
        n_tok_o   = r_tok_c;
        if (is_pix && r_tok_c.last && in_search
            && (!r_tok_c.best_vld || (sum_fin < r_tok_c.best_sum))) begin
            n_tok_o.best_vld = 1'b1;
            n_tok_o.best_sum = sum_fin;
            n_tok_o.best_idx = i_cell_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_b <= '0;
            r_tok_c <= '0;
            r_tok_o <= '0;
            r_sum   <= '0;
        end else begin
            r_tok_b <= i_tok;
            r_tok_c <= r_tok_b;
            r_tok_o <= n_tok_o;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= vqe_pkg::SQ_W'(prod);
    end

    assign o_tok   = r_tok_o;
    assign o_rdata = ram_rdata;

endmodule
